// ===== design/mmf_pkg.sv =====
// shared types and constants for the message mailbox fifo
// no dependencies
package mmf_pkg;

  localparam int MBOX_SLOT_COUNT = 16;
  localparam int MBOX_SLOT_BYTES = 192;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSH_TAKEN   = 3'd0,
    ST_PUSH_DROPPED = 3'd1,
    ST_POP_BYTE     = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_EMPTY_MSG    = 3'd4
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_in;
    logic       last_in;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_out;
    logic        last_out;
    logic [31:0] dropped_count;
  } rsp_t;

endpackage

// ===== design/mmf_ram.sv =====
// single-port-write, single-port-read synchronous ram with a registered read
// depends on nothing
module mmf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/message_mailbox_fifo.sv =====
// message mailbox fifo: ring of message slots fed and drained one byte per transaction
// depends on mmf_pkg and mmf_ram
//
// A mailbox of SLOTS message slots of MSG_BYTES bytes each, kept as a ring with one
// slot always free. A push transaction carries one message byte; last_in marks the
// final byte. The ring is checked once at the first byte of a message: if full, the
// whole message answers "dropped" and the 32-bit wrapping drop counter steps once.
// A slot keeps at most MSG_BYTES-1 bytes (later bytes are ignored but still answer
// "push taken"), and its length stops at the first zero byte. A message becomes
// visible to pops only when its final byte arrives. A pop transaction returns one byte
// of the oldest message with last_out on its final byte; a zero-length message is
// freed with its own status and last_out set; an empty ring answers "empty".
// Sequencing: a push and an empty pop answer from the idle state, a zero-length pop
// from S_POP_LEN and a byte pop from S_POP_DATA, behind the chained registered reads
// of the length memory and then the message memory. The response sits in an output
// register, so the next request is taken while it is being collected.
// Storage: message bytes in a SLOTS*MSG_BYTES x 8 memory, slot lengths in a
// SLOTS-entry memory; neither is cleared at reset, no clearing pass is needed.
module message_mailbox_fifo
  import mmf_pkg::*;
#(
  parameter int SLOTS     = MBOX_SLOT_COUNT,
  parameter int MSG_BYTES = MBOX_SLOT_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int OFF_W     = $clog2(MSG_BYTES);
  localparam int MEM_DEPTH = SLOTS * MSG_BYTES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_POP_LEN  = 3'b010,
    S_POP_DATA = 3'b100
  } state_t;

  state_t state, state_next;

  // ring pointers and per-message progress
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [OFF_W-1:0]  write_offset, write_offset_next;
  logic [OFF_W-1:0]  read_offset, read_offset_next;
  logic [OFF_W-1:0]  write_len, write_len_next;   // shadow of the length being built
  logic [31:0]       drop_total, drop_total_next;
  logic              push_in_progress, push_in_progress_next;
  logic              push_discarding, push_discarding_next;
  logic              zero_byte_seen, zero_byte_seen_next;
  logic              pop_last, pop_last_next;

  // response register
  logic rsp_load;
  rsp_t rsp_next;

  // memory ports
  logic              len_we;
  logic [OFF_W-1:0]  len_rdata;
  logic              msg_we;
  logic [MEM_AW-1:0] msg_waddr, msg_raddr;
  logic [7:0]        msg_rdata;

  // push datapath helpers
  logic             accept;
  logic             starting;
  logic             ring_full;
  logic             disc_e;
  logic [OFF_W-1:0] woff_e;
  logic [OFF_W-1:0] len_e;
  logic             zseen_e;
  logic             room;

  // pop datapath helpers
  logic             ring_empty;
  logic [OFF_W-1:0] pop_off;
  logic             pop_final;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  // a new request waits for the idle state and a response register that is free or being emptied
  assign req_ready  = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept     = req_valid && req_ready;

  assign ring_empty = (read_slot == write_slot);
  assign starting   = !push_in_progress;
  assign ring_full  = (next_slot(write_slot) == read_slot);
  assign disc_e     = starting ? ring_full : push_discarding;
  assign woff_e     = starting ? '0 : write_offset;
  assign len_e      = starting ? '0 : write_len;
  assign zseen_e    = starting ? 1'b0 : zero_byte_seen;
  assign room       = (woff_e < OFF_W'(MSG_BYTES - 1));

  // clamp the read offset to the last stored byte
  assign pop_off    = (read_offset >= len_rdata) ? (len_rdata - OFF_W'(1)) : read_offset;
  assign pop_final  = (pop_off == (len_rdata - OFF_W'(1)));

  assign msg_waddr  = MEM_AW'(write_slot) * MEM_AW'(MSG_BYTES) + MEM_AW'(woff_e);
  assign msg_raddr  = MEM_AW'(read_slot) * MEM_AW'(MSG_BYTES) + MEM_AW'(pop_off);

  always_comb begin
    state_next            = state;
    write_slot_next       = write_slot;
    read_slot_next        = read_slot;
    write_offset_next     = write_offset;
    read_offset_next      = read_offset;
    write_len_next        = write_len;
    drop_total_next       = drop_total;
    push_in_progress_next = push_in_progress;
    push_discarding_next  = push_discarding;
    zero_byte_seen_next   = zero_byte_seen;
    pop_last_next         = pop_last;
    len_we                = 1'b0;
    msg_we                = 1'b0;
    rsp_load              = 1'b0;
    rsp_next              = '{status: ST_PUSH_TAKEN, data_out: 8'd0, last_out: 1'b0,
                              dropped_count: drop_total};

    case (state)
      S_IDLE: begin
        if (accept && req.op == OP_PUSH) begin
          // push byte: all updates land this cycle
          rsp_load = 1'b0;
          if (starting && ring_full) begin
            drop_total_next = drop_total + 32'd1;
          end
          write_offset_next   = woff_e;
          write_len_next      = len_e;
          zero_byte_seen_next = zseen_e;
          if (!disc_e) begin
            len_we = 1'b1;
            if (room) begin
              msg_we              = 1'b1;
              write_offset_next   = woff_e + OFF_W'(1);
              zero_byte_seen_next = zseen_e || (req.data_in == 8'd0);
              if (req.data_in != 8'd0 && !zseen_e) begin
                write_len_next = woff_e + OFF_W'(1);
              end
            end
          end
          if (req.last_in) begin
            if (!disc_e) begin
              write_slot_next = next_slot(write_slot);
            end
            push_in_progress_next = 1'b0;
            push_discarding_next  = 1'b0;
          end else begin
            push_in_progress_next = 1'b1;
            push_discarding_next  = disc_e;
          end
          rsp_load               = 1'b1;
          rsp_next.status        = disc_e ? ST_PUSH_DROPPED : ST_PUSH_TAKEN;
          rsp_next.dropped_count = drop_total_next;
        end else if (accept) begin
          if (ring_empty) begin
            rsp_load        = 1'b1;
            rsp_next.status = ST_EMPTY;
          end else begin
            // length memory is addressed by read_slot; data arrives next cycle
            state_next = S_POP_LEN;
          end
        end
      end
      S_POP_LEN: begin
        if (len_rdata == '0) begin
          read_slot_next    = next_slot(read_slot);
          read_offset_next  = '0;
          rsp_load          = 1'b1;
          rsp_next.status   = ST_EMPTY_MSG;
          rsp_next.last_out = 1'b1;
          state_next        = S_IDLE;
        end else begin
          // message byte read issued at msg_raddr
          pop_last_next = pop_final;
          if (pop_final) begin
            read_slot_next   = next_slot(read_slot);
            read_offset_next = '0;
          end else begin
            read_offset_next = pop_off + OFF_W'(1);
          end
          state_next = S_POP_DATA;
        end
      end
      S_POP_DATA: begin
        rsp_load          = 1'b1;
        rsp_next.status   = ST_POP_BYTE;
        rsp_next.data_out = msg_rdata;
        rsp_next.last_out = pop_last;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      write_slot       <= '0;
      read_slot        <= '0;
      write_offset     <= '0;
      read_offset      <= '0;
      write_len        <= '0;
      drop_total       <= '0;
      push_in_progress <= 1'b0;
      push_discarding  <= 1'b0;
      zero_byte_seen   <= 1'b0;
      pop_last         <= 1'b0;
      rsp_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      write_slot       <= write_slot_next;
      read_slot        <= read_slot_next;
      write_offset     <= write_offset_next;
      read_offset      <= read_offset_next;
      write_len        <= write_len_next;
      drop_total       <= drop_total_next;
      push_in_progress <= push_in_progress_next;
      push_discarding  <= push_discarding_next;
      zero_byte_seen   <= zero_byte_seen_next;
      pop_last         <= pop_last_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload holds while waiting, needs no reset
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // per-slot stored length, rewritten on every push byte of the open slot that is not being dropped
  mmf_ram #(
    .DEPTH (SLOTS),
    .WIDTH (OFF_W)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (write_slot),
    .wdata (write_len_next),
    .raddr (read_slot),
    .rdata (len_rdata)
  );

  // message bytes, row per slot
  mmf_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (8)
  ) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (req.data_in),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

endmodule

// ===== verif/tb_message_mailbox_fifo.sv =====
// self-checking testbench for message_mailbox_fifo: directed and random push/pop traffic
// depends on mmf_pkg and the message_mailbox_fifo rtl; a scoreboard class predicts every response
module tb_message_mailbox_fifo;
  import mmf_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_GAP      = 13;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // mailbox predictor plus queue of responses still owed by the block
  class mailbox_scoreboard;
    logic [7:0]  slot_bytes [MBOX_SLOT_COUNT*MBOX_SLOT_BYTES];
    logic [7:0]  slot_len [MBOX_SLOT_COUNT];
    int unsigned wr_slot, rd_slot, wr_ofs, rd_ofs;
    logic [31:0] drops;
    bit          filling, discarding, zero_seen;
    rsp_t        owed_q [$];
    int          errors;

    function new();
      wr_slot    = 0;
      rd_slot    = 0;
      wr_ofs     = 0;
      rd_ofs     = 0;
      drops      = '0;
      filling    = 0;
      discarding = 0;
      zero_seen  = 0;
      errors     = 0;
    endfunction

    function int unsigned next_slot(int unsigned s);
      return (s + 1) % MBOX_SLOT_COUNT;
    endfunction

    // work out the response for one accepted request transaction
    function void note_request(req_t r);
      rsp_t        e;
      int unsigned len;
      bit          last_byte;
      e = '0;
      e.status = ST_PUSH_TAKEN;
      if (r.op == OP_PUSH) begin
        // ring is checked once, at the first byte of a message
        if (!filling) begin
          if (next_slot(wr_slot) == rd_slot) begin
            drops++;
            discarding = 1;
          end else begin
            discarding = 0;
            wr_ofs = 0;
            zero_seen = 0;
            slot_len[wr_slot] = '0;
          end
          filling = 1;
        end
        if (discarding) begin
          e.status = ST_PUSH_DROPPED;
        end else if (wr_ofs < MBOX_SLOT_BYTES - 1) begin
          slot_bytes[wr_slot*MBOX_SLOT_BYTES + wr_ofs] = r.data_in;
          if (r.data_in == 8'h00) begin
            zero_seen = 1;
          end else if (!zero_seen) begin
            slot_len[wr_slot] = 8'(wr_ofs + 1);
          end
          wr_ofs++;
        end
        if (r.last_in) begin
          if (!discarding) begin
            wr_slot = next_slot(wr_slot);
          end
          filling = 0;
          discarding = 0;
        end
      end else if (rd_slot == wr_slot) begin
        e.status = ST_EMPTY;
      end else begin
        len = slot_len[rd_slot];
        if (len == 0) begin
          rd_slot = next_slot(rd_slot);
          rd_ofs = 0;
          e.status = ST_EMPTY_MSG;
          e.last_out = 1'b1;
        end else begin
          if (rd_ofs >= MBOX_SLOT_BYTES - 1 || rd_ofs >= len) begin
            rd_ofs = len - 1;
          end
          e.status = ST_POP_BYTE;
          e.data_out = slot_bytes[rd_slot*MBOX_SLOT_BYTES + rd_ofs];
          last_byte = (rd_ofs + 1 >= len);
          e.last_out = last_byte;
          if (last_byte) begin
            rd_slot = next_slot(rd_slot);
            rd_ofs = 0;
          end else begin
            rd_ofs++;
          end
        end
      end
      e.dropped_count = drops;
      owed_q.push_back(e);
    endfunction

    // compare one accepted response transaction with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t e;
      bit   bad;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected response: status=%0d data=%h last=%0b drops=%0d",
                   got.status, got.data_out, got.last_out, got.dropped_count);
        end
        return;
      end
      e = owed_q.pop_front();
      bad = 0;
      if (got.status !== e.status) bad = 1;
      if (got.data_out !== e.data_out) bad = 1;
      if (got.last_out !== e.last_out) bad = 1;
      if (got.dropped_count !== e.dropped_count) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected status=%0d data=%h last=%0b drops=%0d",
                   e.status, e.data_out, e.last_out, e.dropped_count);
          $display("          actual   status=%0d data=%h last=%0b drops=%0d",
                   got.status, got.data_out, got.last_out, got.dropped_count);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  mailbox_scoreboard sb = new();

  int items_sent;
  int overlong_left;
  bit req_steady;
  bit rsp_steady;

  message_mailbox_fifo u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // monitor: both channels sampled at the rising edge, request noted before response
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  // alternate between stretches of random idling and stretches of full-rate flow
  initial begin
    req_steady = 0;
    rsp_steady = 0;
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      req_steady = ($urandom_range(0, 2) == 0);
      rsp_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // response side: random stall before each transaction, ready held until it moves
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rsp_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog: cycles with no transaction on either channel
  initial begin
    int idle;
    idle = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one request transaction; valid stays high across back-to-back items
  task automatic send_request(input req_t r);
    int gap;
    gap = req_steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    req_t r;
    r.op = OP_PUSH;
    r.data_in = b;
    r.last_in = last;
    send_request(r);
  endtask

  // pop payload bits are don't-care for the block, so they are randomized
  task automatic pop_byte();
    req_t r;
    r.op = OP_POP;
    r.data_in = 8'($urandom_range(0, 255));
    r.last_in = 1'($urandom_range(0, 1));
    send_request(r);
  endtask

  // zero bytes come often enough to cut stored lengths short
  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 15) == 0) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly short messages, single bytes fairly often, a few at or past the slot capacity
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll == 0 && overlong_left > 0) begin
      overlong_left--;
      return $urandom_range(MBOX_SLOT_BYTES - 1, MBOX_SLOT_BYTES + 4);
    end
    if (roll < 10) return 1;
    return $urandom_range(1, 16);
  endfunction

  // whole message, with the odd pop slipped in between its bytes
  task automatic push_message(input int len, input bit lead_zero);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) pop_byte();
      b = (i == 0 && lead_zero) ? 8'h00 : random_byte();
      push_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int target;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    items_sent = 0;
    overlong_left = 3;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: pop on an empty mailbox
    pop_byte();
    // zero-length message, single max-value byte, zero byte cutting the length short
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    // pop while a message is half pushed: the zero-length message goes first
    push_byte(8'haa, 1'b0);
    push_byte(8'h55, 1'b0);
    pop_byte();
    push_byte(8'h7f, 1'b1);
    // message led by a zero byte, followed by a non-zero one
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b1);
    // drain everything and hit empty again
    repeat (7) pop_byte();

    // random: fill phases run the ring full into drops, drain phases run it empty
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      repeat ($urandom_range(4, 24)) begin
        if (items_sent < target) push_message(pick_length(), $urandom_range(0, 19) == 0);
      end
      repeat ($urandom_range(10, 120)) begin
        if (items_sent < target) pop_byte();
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;

    // wait for every owed response, then keep watching for anything stray
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
